// ===== design/lbf_pkg.sv =====
// Shared types and constants for the LED brightness fade block.
// Used by every module of the block but lbf_ram; depends on nothing.
package lbf_pkg;

    localparam int MAX_LEDS_DEF = 16;

    localparam int FUNC_W     = 2;
    localparam int INDEX_W    = 6;
    localparam int COLOR_W    = 8;
    localparam int PIX_W      = 3 * COLOR_W;
    localparam int LEVEL_W    = 7;
    localparam int INTERVAL_W = 16;
    localparam int TICK_W     = 17;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_BASE    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_FRAME   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_RUN    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FINISH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RESET  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LOAD   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_START    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INHERIT  = 3'd5;

    localparam logic [LEVEL_W-1:0]    START_RST    = 7'd0;
    localparam logic [LEVEL_W-1:0]    END_RST      = 7'd100;
    localparam logic [LEVEL_W-1:0]    STEP_RST     = 7'd1;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd1;
    localparam logic [LEVEL_W-1:0]    COUNT_RST    = 7'd16;

    typedef enum logic [1:0] {
        CMD_TICK       = 2'd0,
        CMD_RESTART    = 2'd1,
        CMD_LOAD_BASE  = 2'd2,
        CMD_LOAD_FRAME = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [INDEX_W-1:0]   led_index;
        logic [PIX_W-1:0]     color;
    } cmd_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]    start_level;
        logic [LEVEL_W-1:0]    end_level;
        logic [LEVEL_W-1:0]    step_size;
        logic [INTERVAL_W-1:0] tick_interval;
        logic [LEVEL_W-1:0]    led_count;
        logic                  inherit_frame;
    } cfg_t;

endpackage

// ===== design/lbf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the base color and frame stores.
module lbf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/lbf_front.sv =====
// Front end: configuration registers and classification of input words.
// Depends on lbf_pkg; feeds lbf_cmd_queue.
module lbf_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [lbf_pkg::FUNC_W-1:0]      s_func,
    input  logic [lbf_pkg::INDEX_W-1:0]     s_led_index,
    input  logic [lbf_pkg::COLOR_W-1:0]     s_red_in,
    input  logic [lbf_pkg::COLOR_W-1:0]     s_green_in,
    input  logic [lbf_pkg::COLOR_W-1:0]     s_blue_in,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lbf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lbf_pkg::CFG_DATA_W-1:0]  cfg_data,
    output lbf_pkg::cfg_t                   cfg,
    input  logic                            q_full,
    output logic                            push,
    output lbf_pkg::cmd_t                   push_cmd
);
    import lbf_pkg::*;

    cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;
    assign s_ready   = !q_full;
    assign push      = s_valid && s_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_START:    cfg_next.start_level   = cfg_data[LEVEL_W-1:0];
                CFG_END:      cfg_next.end_level     = cfg_data[LEVEL_W-1:0];
                CFG_STEP:     cfg_next.step_size     = cfg_data[LEVEL_W-1:0];
                CFG_INTERVAL: cfg_next.tick_interval = cfg_data[INTERVAL_W-1:0];
                CFG_COUNT:    cfg_next.led_count     = cfg_data[LEVEL_W-1:0];
                CFG_INHERIT:  cfg_next.inherit_frame = cfg_data[0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_level   <= START_RST;
            cfg_reg.end_level     <= END_RST;
            cfg_reg.step_size     <= STEP_RST;
            cfg_reg.tick_interval <= INTERVAL_RST;
            cfg_reg.led_count     <= COUNT_RST;
            cfg_reg.inherit_frame <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // classify: a tick with zero step acts as restart
    always_comb begin
        push_cmd.led_index = s_led_index;
        push_cmd.color     = {s_red_in, s_green_in, s_blue_in};
        unique case (s_func)
            FUNC_TICK: begin
                push_cmd.kind = (cfg_reg.step_size == '0) ? CMD_RESTART : CMD_TICK;
            end
            FUNC_RESTART: push_cmd.kind = CMD_RESTART;
            FUNC_BASE:    push_cmd.kind = CMD_LOAD_BASE;
            FUNC_FRAME:   push_cmd.kind = CMD_LOAD_FRAME;
            default:      push_cmd.kind = CMD_RESTART;
        endcase
    end

endmodule

// ===== design/lbf_cmd_queue.sv =====
// Short command queue between front end and back end.
// Depends on lbf_pkg for the command word type and depth.
module lbf_cmd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  lbf_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output lbf_pkg::cmd_t head_cmd
);
    import lbf_pkg::*;

    cmd_t               mem_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_AW:0]   count_reg, count_next;

    assign full       = (count_reg == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/lbf_back.sv =====
// Back end: ramp sequencer, base/frame stores and the scaling pipeline.
// Depends on lbf_pkg and lbf_ram; drains commands from lbf_cmd_queue.
module lbf_back #(
    parameter int MAX_LEDS = lbf_pkg::MAX_LEDS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lbf_pkg::cfg_t                  cfg,
    input  logic                           cmd_valid,
    input  lbf_pkg::cmd_t                  cmd,
    output logic                           cmd_pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [lbf_pkg::INDEX_W-1:0]    m_pixel_index,
    output logic [lbf_pkg::COLOR_W-1:0]    m_red_out,
    output logic [lbf_pkg::COLOR_W-1:0]    m_green_out,
    output logic [lbf_pkg::COLOR_W-1:0]    m_blue_out,
    output logic [lbf_pkg::LEVEL_W-1:0]    m_level_out,
    output logic [lbf_pkg::STATUS_W-1:0]   m_status,
    output logic                           m_last
);
    import lbf_pkg::*;

    localparam int IDX_W       = $clog2(MAX_LEDS);
    localparam int PROD_W      = COLOR_W + LEVEL_W;
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_W     = 16;
    localparam int QFULL_W     = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_100 = 16'd41944;
    localparam logic [PROD_W-1:0]  HALF_100  = 15'd50;

    typedef enum logic [4:0] {
        S_IDLE       = 5'b00001,
        S_INIT       = 5'b00010,
        S_INIT_DRAIN = 5'b00100,
        S_CHECK      = 5'b01000,
        S_EMIT       = 5'b10000
    } state_t;

    // floor(x/100) for x below 2^15, saturated to a color byte; callers add 50
    function automatic logic [COLOR_W-1:0] div100_sat(input logic [PROD_W-1:0] x);
        logic [QFULL_W-1:0] p;
        logic [COLOR_W:0]   q;
        p = QFULL_W'(x) * QFULL_W'(RECIP_100);
        q = p[RECIP_SHIFT+COLOR_W:RECIP_SHIFT];
        return q[COLOR_W] ? {COLOR_W{1'b1}} : q[COLOR_W-1:0];
    endfunction

    state_t              state_reg, state_next;
    logic [TICK_W-1:0]   tick_count_reg, tick_count_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic [IDX_W-1:0]    sweep_reg, sweep_next;
    logic [MAX_LEDS-1:0] base_vld_reg, base_vld_next;
    logic [MAX_LEDS-1:0] frame_vld_reg, frame_vld_next;
    logic                p1_v_reg, p1_v_next;
    logic                p2_v_reg, p2_v_next;
    logic                out_v_reg, out_v_next;

    logic                p1_init_reg, p1_last_reg, p1_ent_reg;
    logic [IDX_W-1:0]    p1_idx_reg;
    logic                p2_init_reg, p2_last_reg;
    logic [IDX_W-1:0]    p2_idx_reg;
    logic [PROD_W-1:0]   p2_red_reg, p2_green_reg, p2_blue_reg;

    logic [INDEX_W-1:0]  out_idx_reg, out_idx_next;
    logic [PIX_W-1:0]    out_px_reg, out_px_next;
    logic [LEVEL_W-1:0]  out_level_reg, out_level_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_last_reg, out_last_next;
    logic                out_load;

    logic                base_we, frame_we;
    logic [IDX_W-1:0]    base_wa, frame_wa;
    logic [PIX_W-1:0]    base_wd, frame_wd;
    logic [PIX_W-1:0]    base_rd, frame_rd;

    logic                adv, drained, issue, sweep_last, wb_fire;
    logic [LEVEL_W-1:0]  n_clamp;
    logic [IDX_W-1:0]    last_idx;
    logic [PIX_W-1:0]    src_px, scaled_px;
    logic [PROD_W-1:0]   prod_red, prod_green, prod_blue;
    logic                up, fin, tick_roll, idx_ok;
    logic [LEVEL_W:0]    diff;
    logic [LEVEL_W-1:0]  level_step;
    logic [TICK_W-1:0]   tick_base;

    lbf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LEDS)) u_base_ram (
        .aclk    (aclk),
        .wr_en   (base_we),
        .wr_addr (base_wa),
        .wr_data (base_wd),
        .rd_en   (issue),
        .rd_addr (sweep_reg),
        .rd_data (base_rd)
    );

    lbf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LEDS)) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (frame_we),
        .wr_addr (frame_wa),
        .wr_data (frame_wd),
        .rd_en   (issue),
        .rd_addr (sweep_reg),
        .rd_data (frame_rd)
    );

    always_comb begin
        if (cfg.led_count > LEVEL_W'(MAX_LEDS)) begin
            n_clamp = LEVEL_W'(MAX_LEDS);
        end else if (cfg.led_count == '0) begin
            n_clamp = LEVEL_W'(1);
        end else begin
            n_clamp = cfg.led_count;
        end
    end
    assign last_idx = IDX_W'(n_clamp - LEVEL_W'(1));

    assign adv        = !out_v_reg || m_ready;
    assign drained    = !p1_v_reg && !p2_v_reg;
    assign issue      = adv && (state_reg == S_INIT || state_reg == S_EMIT);
    assign sweep_last = (sweep_reg == last_idx);
    assign wb_fire    = adv && p2_v_reg;
    assign cmd_pop    = (state_reg == S_IDLE) && cmd_valid && adv && drained;
    assign idx_ok     = {1'b0, cmd.led_index} < (INDEX_W+1)'(MAX_LEDS);

    assign src_px = !p1_ent_reg ? '0 :
                    (p1_init_reg && cfg.inherit_frame) ? frame_rd : base_rd;
    assign prod_red   = PROD_W'({7'd0, src_px[PIX_W-1 -: COLOR_W]} * {8'd0, level_reg})
                        + HALF_100;
    assign prod_green = PROD_W'({7'd0, src_px[2*COLOR_W-1 -: COLOR_W]} * {8'd0, level_reg})
                        + HALF_100;
    assign prod_blue  = PROD_W'({7'd0, src_px[COLOR_W-1:0]} * {8'd0, level_reg})
                        + HALF_100;
    assign scaled_px  = {div100_sat(p2_red_reg), div100_sat(p2_green_reg),
                         div100_sat(p2_blue_reg)};

    assign up         = cfg.start_level <= cfg.end_level;
    assign diff       = up ? ({1'b0, cfg.end_level} - {1'b0, level_reg})
                           : ({1'b0, level_reg} - {1'b0, cfg.end_level});
    assign fin        = $signed(diff) < $signed({1'b0, cfg.step_size});
    assign tick_roll  = tick_count_reg >= {1'b0, cfg.tick_interval};
    assign level_step = up ? level_reg + cfg.step_size : level_reg - cfg.step_size;
    assign tick_base  = tick_roll ? '0 : tick_count_reg;

    always_comb begin
        state_next      = state_reg;
        tick_count_next = tick_count_reg;
        level_next      = level_reg;
        sweep_next      = sweep_reg;
        base_vld_next   = base_vld_reg;
        frame_vld_next  = frame_vld_reg;
        p1_v_next       = adv ? issue : p1_v_reg;
        p2_v_next       = adv ? p1_v_reg : p2_v_reg;
        out_v_next      = out_v_reg && !m_ready;
        out_load        = 1'b0;
        out_idx_next    = INDEX_W'(p2_idx_reg);
        out_px_next     = scaled_px;
        out_level_next  = level_reg;
        out_status_next = ST_RUN;
        out_last_next   = p2_last_reg;
        base_we         = 1'b0;
        base_wa         = p2_idx_reg;
        base_wd         = scaled_px;
        frame_we        = 1'b0;
        frame_wa        = p2_idx_reg;
        frame_wd        = scaled_px;

        // write back scaled pixels; emit them outside the first-tick load
        if (wb_fire) begin
            frame_we                   = 1'b1;
            frame_vld_next[p2_idx_reg] = 1'b1;
            if (p2_init_reg && cfg.inherit_frame) begin
                base_we                   = 1'b1;
                base_vld_next[p2_idx_reg] = 1'b1;
            end
            if (!p2_init_reg) begin
                out_load   = 1'b1;
                out_v_next = 1'b1;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (cmd_pop) begin
                    unique case (cmd.kind)
                        CMD_LOAD_BASE, CMD_LOAD_FRAME: begin
                            if (idx_ok && cmd.kind == CMD_LOAD_BASE) begin
                                base_we                                = 1'b1;
                                base_wa                                = cmd.led_index[IDX_W-1:0];
                                base_wd                                = cmd.color;
                                base_vld_next[cmd.led_index[IDX_W-1:0]] = 1'b1;
                            end
                            if (idx_ok && cmd.kind == CMD_LOAD_FRAME) begin
                                frame_we                                = 1'b1;
                                frame_wa                                = cmd.led_index[IDX_W-1:0];
                                frame_wd                                = cmd.color;
                                frame_vld_next[cmd.led_index[IDX_W-1:0]] = 1'b1;
                            end
                            out_load        = 1'b1;
                            out_v_next      = 1'b1;
                            out_idx_next    = cmd.led_index;
                            out_px_next     = cmd.color;
                            out_status_next = ST_LOAD;
                            out_last_next   = 1'b1;
                        end
                        CMD_RESTART: begin
                            tick_count_next = '0;
                            level_next      = cfg.start_level;
                            out_load        = 1'b1;
                            out_v_next      = 1'b1;
                            out_idx_next    = '0;
                            out_px_next     = '0;
                            out_level_next  = cfg.start_level;
                            out_status_next = ST_RESET;
                            out_last_next   = 1'b1;
                        end
                        CMD_TICK: begin
                            if (tick_count_reg == '0) begin
                                level_next = cfg.start_level;
                                sweep_next = '0;
                                state_next = S_INIT;
                            end else begin
                                state_next = S_CHECK;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_INIT: begin
                if (issue) begin
                    if (sweep_last) begin
                        state_next = S_INIT_DRAIN;
                    end else begin
                        sweep_next = sweep_reg + 1'b1;
                    end
                end
            end
            S_INIT_DRAIN: begin
                if (drained) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (adv) begin
                    if (fin) begin
                        out_load        = 1'b1;
                        out_v_next      = 1'b1;
                        out_idx_next    = '0;
                        out_px_next     = '0;
                        out_status_next = ST_FINISH;
                        out_last_next   = 1'b1;
                        state_next      = S_IDLE;
                    end else begin
                        if (tick_roll) begin
                            level_next = level_step;
                        end
                        tick_count_next = tick_base + 1'b1;
                        sweep_next      = '0;
                        state_next      = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (issue) begin
                    if (sweep_last) begin
                        state_next = S_IDLE;
                    end else begin
                        sweep_next = sweep_reg + 1'b1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            tick_count_reg <= '0;
            level_reg      <= '0;
            sweep_reg      <= '0;
            base_vld_reg   <= '0;
            frame_vld_reg  <= '0;
            p1_v_reg       <= 1'b0;
            p2_v_reg       <= 1'b0;
            out_v_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            tick_count_reg <= tick_count_next;
            level_reg      <= level_next;
            sweep_reg      <= sweep_next;
            base_vld_reg   <= base_vld_next;
            frame_vld_reg  <= frame_vld_next;
            p1_v_reg       <= p1_v_next;
            p2_v_reg       <= p2_v_next;
            out_v_reg      <= out_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_init_reg  <= (state_reg == S_INIT);
            p1_last_reg  <= sweep_last;
            p1_idx_reg   <= sweep_reg;
            p1_ent_reg   <= (state_reg == S_INIT && cfg.inherit_frame) ?
                            frame_vld_reg[sweep_reg] : base_vld_reg[sweep_reg];
            p2_init_reg  <= p1_init_reg;
            p2_last_reg  <= p1_last_reg;
            p2_idx_reg   <= p1_idx_reg;
            p2_red_reg   <= prod_red;
            p2_green_reg <= prod_green;
            p2_blue_reg  <= prod_blue;
        end
        if (out_load) begin
            out_idx_reg    <= out_idx_next;
            out_px_reg     <= out_px_next;
            out_level_reg  <= out_level_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_valid       = out_v_reg;
    assign m_pixel_index = out_idx_reg;
    assign m_red_out     = out_px_reg[PIX_W-1 -: COLOR_W];
    assign m_green_out   = out_px_reg[2*COLOR_W-1 -: COLOR_W];
    assign m_blue_out    = out_px_reg[COLOR_W-1:0];
    assign m_level_out   = out_level_reg;
    assign m_status      = out_status_reg;
    assign m_last        = out_last_reg;

endmodule

// ===== design/led_brightness_fade.sv =====
// LED brightness fade: ticked brightness ramp over an LED frame.
// Input words enter s_*, results leave m_*, both valid/ready; registers are
// written through cfg_valid/cfg_ready with cfg_index and cfg_data, always ready.
// Register indexes: 0 start level, 1 end level, 2 step, 3 tick interval,
// 4 LED count, 5 inherit mode. Write them only while the block is idle.
// A load word (base or frame entry) returns one acknowledge word.
// A restart, or a tick with zero step, returns one word.
// A running tick returns one word per LED in use, one per cycle while
// m_ready does not stall, a rate set by the single read port of the base
// store; a tick that finds the ramp at its end returns one finish word.
// The first tick after a restart first sweeps the stores once more.
// A two-word command queue parts input from the sequencer, so input words
// are still taken while results wait until the queue fills; a stalled m_ready
// holds the result word and freezes the scaling pipeline in place.
// Reset is synchronous on aresetn: registers take their defaults, level and
// tick count clear, every base and frame entry reads as black, no reset pass.
// Depends on lbf_pkg, lbf_front, lbf_cmd_queue, lbf_back and lbf_ram.
module led_brightness_fade #(
    parameter int MAX_LEDS = lbf_pkg::MAX_LEDS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [lbf_pkg::FUNC_W-1:0]     s_func,
    input  logic [lbf_pkg::INDEX_W-1:0]    s_led_index,
    input  logic [lbf_pkg::COLOR_W-1:0]    s_red_in,
    input  logic [lbf_pkg::COLOR_W-1:0]    s_green_in,
    input  logic [lbf_pkg::COLOR_W-1:0]    s_blue_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [lbf_pkg::INDEX_W-1:0]    m_pixel_index,
    output logic [lbf_pkg::COLOR_W-1:0]    m_red_out,
    output logic [lbf_pkg::COLOR_W-1:0]    m_green_out,
    output logic [lbf_pkg::COLOR_W-1:0]    m_blue_out,
    output logic [lbf_pkg::LEVEL_W-1:0]    m_level_out,
    output logic [lbf_pkg::STATUS_W-1:0]   m_status,
    output logic                           m_last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lbf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lbf_pkg::*;

    cfg_t cfg;
    cmd_t push_cmd, head_cmd;
    logic push, q_full, pop, head_valid;

    lbf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_led_index (s_led_index),
        .s_red_in    (s_red_in),
        .s_green_in  (s_green_in),
        .s_blue_in   (s_blue_in),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cfg         (cfg),
        .q_full      (q_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    lbf_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    lbf_back #(.MAX_LEDS(MAX_LEDS)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .cmd_valid     (head_valid),
        .cmd           (head_cmd),
        .cmd_pop       (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_index (m_pixel_index),
        .m_red_out     (m_red_out),
        .m_green_out   (m_green_out),
        .m_blue_out    (m_blue_out),
        .m_level_out   (m_level_out),
        .m_status      (m_status),
        .m_last        (m_last)
    );

endmodule

// ===== tb/led_brightness_fade_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for led_brightness_fade: directed table, then random ramp phases.
// Keeps its own fade predictor and checks every result word; depends on lbf_pkg and the RTL.
module led_brightness_fade_test;
    import lbf_pkg::*;

    localparam int MAX_LEDS    = MAX_LEDS_DEF;
    localparam int RAND_WORDS  = 210;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE      = 2 * MAX_LEDS + 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [INDEX_W-1:0]  pixel;
        logic [COLOR_W-1:0]  red;
        logic [COLOR_W-1:0]  green;
        logic [COLOR_W-1:0]  blue;
        logic [LEVEL_W-1:0]  level;
        logic [STATUS_W-1:0] status;
        logic                last_flag;
    } fade_word_t;

    typedef struct packed {
        logic                  is_cfg;
        logic                  typed;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [FUNC_W-1:0]     fn;
        logic [INDEX_W-1:0]    idx;
        logic [COLOR_W-1:0]    red;
        logic [COLOR_W-1:0]    green;
        logic [COLOR_W-1:0]    blue;
        logic [STATUS_W-1:0]   exp_status;
        logic [LEVEL_W-1:0]    exp_level;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [FUNC_W-1:0]     s_func = FUNC_TICK;
    logic [INDEX_W-1:0]    s_led_index = '0;
    logic [COLOR_W-1:0]    s_red_in = '0;
    logic [COLOR_W-1:0]    s_green_in = '0;
    logic [COLOR_W-1:0]    s_blue_in = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [INDEX_W-1:0]    m_pixel_index;
    logic [COLOR_W-1:0]    m_red_out;
    logic [COLOR_W-1:0]    m_green_out;
    logic [COLOR_W-1:0]    m_blue_out;
    logic [LEVEL_W-1:0]    m_level_out;
    logic [STATUS_W-1:0]   m_status;
    logic                  m_last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_START;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    led_brightness_fade #(.MAX_LEDS(MAX_LEDS)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_led_index   (s_led_index),
        .s_red_in      (s_red_in),
        .s_green_in    (s_green_in),
        .s_blue_in     (s_blue_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_index (m_pixel_index),
        .m_red_out     (m_red_out),
        .m_green_out   (m_green_out),
        .m_blue_out    (m_blue_out),
        .m_level_out   (m_level_out),
        .m_status      (m_status),
        .m_last        (m_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // predictor state and register copies
    logic [LEVEL_W-1:0]    cfg_start    = START_RST;
    logic [LEVEL_W-1:0]    cfg_end      = END_RST;
    logic [LEVEL_W-1:0]    cfg_step     = STEP_RST;
    logic [INTERVAL_W-1:0] cfg_interval = INTERVAL_RST;
    logic [LEVEL_W-1:0]    cfg_count    = COUNT_RST;
    logic                  cfg_inherit  = 1'b0;
    logic [TICK_W-1:0]     tick_cnt     = '0;
    logic [LEVEL_W-1:0]    fade_level   = '0;
    logic [PIX_W-1:0]      base_mem  [MAX_LEDS];
    logic [PIX_W-1:0]      frame_mem [MAX_LEDS];

    fade_word_t pending_words[$];
    stim_row_t  dir_rows[$];
    bit         no_idle = 1'b0;

    int mismatches    = 0;
    int words_sent    = 0;
    int words_checked = 0;
    int cfg_writes    = 0;
    int phases        = 0;
    int n_run         = 0;
    int n_finish      = 0;
    int n_restart     = 0;
    int n_load        = 0;

    initial begin
        for (int i = 0; i < MAX_LEDS; i++) begin
            base_mem[i]  = '0;
            frame_mem[i] = '0;
        end
    end

    function automatic logic [COLOR_W-1:0] scale_chan(logic [COLOR_W-1:0] c,
                                                     logic [LEVEL_W-1:0] lv);
        int v;
        v = (int'(c) * int'(lv) + 50) / 100;
        return (v > 255) ? 8'hFF : v[COLOR_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] scale_pixel(logic [PIX_W-1:0] px,
                                                    logic [LEVEL_W-1:0] lv);
        return {scale_chan(px[23:16], lv), scale_chan(px[15:8], lv), scale_chan(px[7:0], lv)};
    endfunction

    task automatic queue_word(input logic [INDEX_W-1:0] pix, input logic [PIX_W-1:0] color,
                              input logic [STATUS_W-1:0] st, input logic lst);
        fade_word_t w;
        w = '{pix, color[23:16], color[15:8], color[7:0], fade_level, st, lst};
        pending_words.push_back(w);
    endtask

    task automatic fade_predict(input logic [FUNC_W-1:0] fn, input logic [INDEX_W-1:0] idx,
                                input logic [PIX_W-1:0] color);
        int  n;
        bit  up;
        bit  fin;
        logic [PIX_W-1:0] src;
        if (fn == FUNC_BASE || fn == FUNC_FRAME) begin
            if (idx < MAX_LEDS) begin
                if (fn == FUNC_BASE) base_mem[idx] = color;
                else frame_mem[idx] = color;
            end
            queue_word(idx, color, ST_LOAD, 1'b1);
            return;
        end
        if (fn == FUNC_RESTART || cfg_step == 0) begin
            tick_cnt   = '0;
            fade_level = cfg_start;
            queue_word('0, '0, ST_RESET, 1'b1);
            return;
        end
        n = (cfg_count > MAX_LEDS) ? MAX_LEDS : int'(cfg_count);
        if (n == 0) n = 1;
        if (tick_cnt == 0) begin
            fade_level = cfg_start;
            for (int i = 0; i < n; i++) begin
                src = cfg_inherit ? frame_mem[i] : base_mem[i];
                frame_mem[i] = scale_pixel(src, fade_level);
                if (cfg_inherit) base_mem[i] = frame_mem[i];
            end
        end
        up = (cfg_start <= cfg_end);
        if (up) fin = (int'(cfg_end) - int'(fade_level)) < int'(cfg_step);
        else fin = (int'(fade_level) - int'(cfg_end)) < int'(cfg_step);
        if (fin) begin
            queue_word('0, '0, ST_FINISH, 1'b1);
            return;
        end
        if (tick_cnt >= cfg_interval) begin
            tick_cnt   = '0;
            fade_level = up ? fade_level + cfg_step : fade_level - cfg_step;
        end
        tick_cnt = tick_cnt + 1'b1;
        for (int i = 0; i < n; i++) begin
            frame_mem[i] = scale_pixel(base_mem[i], fade_level);
            queue_word(i[INDEX_W-1:0], frame_mem[i], ST_RUN, (i + 1 == n));
        end
    endtask

    task automatic note_mismatch(input string what, input fade_word_t want, input fade_word_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, what);
            $display("  expected pix %0d rgb %02h %02h %02h lvl %0d st %0d last %0d",
                     want.pixel, want.red, want.green, want.blue, want.level,
                     want.status, want.last_flag);
            $display("  actual   pix %0d rgb %02h %02h %02h lvl %0d st %0d last %0d",
                     got.pixel, got.red, got.green, got.blue, got.level,
                     got.status, got.last_flag);
        end
    endtask

    fade_word_t got_word;
    fade_word_t want_word;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_word = '{m_pixel_index, m_red_out, m_green_out, m_blue_out,
                         m_level_out, m_status, m_last};
            words_checked++;
            case (m_status)
                ST_RUN:    n_run++;
                ST_FINISH: n_finish++;
                ST_RESET:  n_restart++;
                default:   n_load++;
            endcase
            if (pending_words.size() == 0) begin
                note_mismatch("result word with nothing expected", '0, got_word);
            end else begin
                want_word = pending_words.pop_front();
                if (got_word.pixel != want_word.pixel || got_word.red != want_word.red ||
                    got_word.green != want_word.green || got_word.blue != want_word.blue ||
                    got_word.level != want_word.level || got_word.status != want_word.status ||
                    got_word.last_flag != want_word.last_flag)
                    note_mismatch("result word mismatch", want_word, got_word);
            end
        end
    end

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 99) < 25) begin
                stall = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2)
                                                     : $urandom_range(9, 39);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [INDEX_W-1:0] idx,
                             input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                             input logic [COLOR_W-1:0] b);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= fn;
        s_led_index <= idx;
        s_red_in    <= r;
        s_green_in  <= g;
        s_blue_in   <= b;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        fade_predict(fn, idx, {r, g, b});
    endtask

    task automatic send_random(input logic [FUNC_W-1:0] fn);
        logic [INDEX_W-1:0] idx;
        if ((fn == FUNC_BASE || fn == FUNC_FRAME) && $urandom_range(0, 99) < 80)
            idx = $urandom_range(0, MAX_LEDS - 1);
        else
            idx = $urandom_range(0, 63);
        send_word(fn, idx, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255));
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] ri, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (ri)
            CFG_START:    cfg_start    = data[LEVEL_W-1:0];
            CFG_END:      cfg_end      = data[LEVEL_W-1:0];
            CFG_STEP:     cfg_step     = data[LEVEL_W-1:0];
            CFG_INTERVAL: cfg_interval = data;
            CFG_COUNT:    cfg_count    = data[LEVEL_W-1:0];
            CFG_INHERIT:  cfg_inherit  = data[0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] v, int w);
        logic [CFG_DATA_W-1:0] j;
        j = $urandom_range(0, 65535);
        return ($urandom_range(0, 1) != 0) ? (v | (j << w)) : v;
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(0, 100) : $urandom_range(101, 127);
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_count();
        if ($urandom_range(0, 99) < 70) return $urandom_range(2, MAX_LEDS);
        case ($urandom_range(0, 4))
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return $urandom_range(MAX_LEDS + 1, 63);
            3:       return 7'd64;
            default: return 7'd127;
        endcase
    endfunction

    task automatic random_setting(input int ph);
        logic [LEVEL_W-1:0]    st;
        logic [LEVEL_W-1:0]    en;
        logic [LEVEL_W-1:0]    sp;
        logic [LEVEL_W-1:0]    cn;
        logic [INTERVAL_W-1:0] iv;
        logic                  inh;
        int                    r;
        case (ph)
            0: begin
                st = 7'd0; en = 7'd100; sp = 7'd1; iv = '0; cn = MAX_LEDS; inh = 1'b0;
            end
            1: begin
                st = 7'd100; en = 7'd0; sp = 7'd100; iv = 16'hFFFF; cn = 7'd64; inh = 1'b1;
            end
            default: begin
                st = pick_level();
                en = pick_level();
                r  = $urandom_range(0, 99);
                sp = (r < 10) ? 7'd0 : (r < 75) ? $urandom_range(1, 20) : $urandom_range(21, 127);
                r  = $urandom_range(0, 99);
                iv = (r < 40) ? 16'd0 : (r < 80) ? $urandom_range(1, 3) :
                     (r < 90) ? $urandom_range(4, 20) : $urandom_range(0, 65535);
                cn  = pick_count();
                inh = $urandom_range(0, 1);
            end
        endcase
        cfg_write(CFG_START, with_junk(st, LEVEL_W));
        cfg_write(CFG_END, with_junk(en, LEVEL_W));
        cfg_write(CFG_STEP, with_junk(sp, LEVEL_W));
        cfg_write(CFG_INTERVAL, iv);
        cfg_write(CFG_COUNT, with_junk(cn, LEVEL_W));
        cfg_write(CFG_INHERIT, with_junk(inh, 1));
        if (ph == 2) begin
            cfg_write(CFG_SPARE_A, $urandom_range(0, 65535));
            cfg_write(CFG_SPARE_B, $urandom_range(0, 65535));
        end
    endtask

    function automatic stim_row_t item_row(logic [FUNC_W-1:0] fn, logic [INDEX_W-1:0] idx,
                                           logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                                           logic [COLOR_W-1:0] b);
        stim_row_t row;
        row = '0;
        row.fn = fn; row.idx = idx; row.red = r; row.green = g; row.blue = b;
        return row;
    endfunction

    function automatic stim_row_t chk_row(logic [FUNC_W-1:0] fn, logic [INDEX_W-1:0] idx,
                                          logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                                          logic [COLOR_W-1:0] b, logic [STATUS_W-1:0] st,
                                          logic [LEVEL_W-1:0] lv);
        stim_row_t row;
        row = item_row(fn, idx, r, g, b);
        row.typed = 1'b1; row.exp_status = st; row.exp_level = lv;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] ri, logic [CFG_DATA_W-1:0] d);
        stim_row_t row;
        row = '0;
        row.is_cfg = 1'b1; row.reg_idx = ri; row.reg_data = d;
        return row;
    endfunction

    initial begin
        stim_row_t  row;
        fade_word_t typed_word;
        int         random_words;
        int         ph;
        int         nw;
        int         phase_len;
        int         directed;

        dir_rows.push_back(chk_row(FUNC_RESTART, 0, 8'h00, 8'h00, 8'h00, ST_RESET, 0));
        dir_rows.push_back(chk_row(FUNC_BASE, 0, 8'hFF, 8'hFF, 8'hFF, ST_LOAD, 0));
        dir_rows.push_back(chk_row(FUNC_BASE, 1, 8'h80, 8'h40, 8'h01, ST_LOAD, 0));
        dir_rows.push_back(chk_row(FUNC_BASE, 15, 8'h7F, 8'hFE, 8'h01, ST_LOAD, 0));
        dir_rows.push_back(chk_row(FUNC_FRAME, 63, 8'hFF, 8'h00, 8'hFF, ST_LOAD, 0));
        dir_rows.push_back(chk_row(FUNC_FRAME, 16, 8'h12, 8'h34, 8'h56, ST_LOAD, 0));
        dir_rows.push_back(item_row(FUNC_TICK, 0, 8'h00, 8'h00, 8'h00));
        dir_rows.push_back(item_row(FUNC_TICK, 63, 8'hFF, 8'hFF, 8'hFF));
        dir_rows.push_back(item_row(FUNC_TICK, 7, 8'h5A, 8'hA5, 8'h3C));
        // zero step holds the block in restart
        dir_rows.push_back(cfg_row(CFG_STEP, 16'd0));
        dir_rows.push_back(chk_row(FUNC_TICK, 0, 8'h00, 8'h00, 8'h00, ST_RESET, 0));
        // downward ramp by a full step to finished
        dir_rows.push_back(cfg_row(CFG_START, 16'd100));
        dir_rows.push_back(cfg_row(CFG_END, 16'd0));
        dir_rows.push_back(cfg_row(CFG_STEP, 16'd100));
        dir_rows.push_back(chk_row(FUNC_RESTART, 0, 8'h00, 8'h00, 8'h00, ST_RESET, 100));
        dir_rows.push_back(item_row(FUNC_TICK, 0, 8'h00, 8'h00, 8'h00));
        dir_rows.push_back(item_row(FUNC_TICK, 0, 8'h00, 8'h00, 8'h00));
        dir_rows.push_back(item_row(FUNC_TICK, 0, 8'h00, 8'h00, 8'h00));
        // inherit at a level above 100, zero LED count
        dir_rows.push_back(cfg_row(CFG_START, 16'd127));
        dir_rows.push_back(cfg_row(CFG_END, 16'd127));
        dir_rows.push_back(cfg_row(CFG_STEP, 16'd1));
        dir_rows.push_back(cfg_row(CFG_INHERIT, 16'd1));
        dir_rows.push_back(cfg_row(CFG_COUNT, 16'd0));
        dir_rows.push_back(chk_row(FUNC_RESTART, 0, 8'h00, 8'h00, 8'h00, ST_RESET, 127));
        dir_rows.push_back(chk_row(FUNC_FRAME, 0, 8'hFF, 8'hFF, 8'hFF, ST_LOAD, 127));
        dir_rows.push_back(item_row(FUNC_TICK, 0, 8'h00, 8'h00, 8'h00));
        // oversized LED count, zero interval, ramp past 100
        dir_rows.push_back(cfg_row(CFG_COUNT, 16'd127));
        dir_rows.push_back(cfg_row(CFG_START, 16'd100));
        dir_rows.push_back(cfg_row(CFG_INTERVAL, 16'd0));
        dir_rows.push_back(chk_row(FUNC_RESTART, 0, 8'h00, 8'h00, 8'h00, ST_RESET, 100));
        dir_rows.push_back(item_row(FUNC_TICK, 0, 8'h00, 8'h00, 8'h00));
        dir_rows.push_back(item_row(FUNC_TICK, 0, 8'h00, 8'h00, 8'h00));
        // two LEDs, longest interval
        dir_rows.push_back(cfg_row(CFG_INHERIT, 16'd0));
        dir_rows.push_back(cfg_row(CFG_COUNT, 16'd2));
        dir_rows.push_back(cfg_row(CFG_INTERVAL, 16'hFFFF));
        dir_rows.push_back(cfg_row(CFG_START, 16'd0));
        dir_rows.push_back(cfg_row(CFG_END, 16'd100));
        dir_rows.push_back(item_row(FUNC_FRAME, 1, 8'hC3, 8'h3C, 8'h81));
        dir_rows.push_back(item_row(FUNC_TICK, 0, 8'h00, 8'h00, 8'h00));
        dir_rows.push_back(item_row(FUNC_TICK, 0, 8'h00, 8'h00, 8'h00));

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.is_cfg) begin
                drain_results();
                cfg_write(row.reg_idx, row.reg_data);
            end else begin
                send_word(row.fn, row.idx, row.red, row.green, row.blue);
                if (row.typed) begin
                    // swap the predicted word for the one typed in the table
                    typed_word = '0;
                    typed_word.status    = row.exp_status;
                    typed_word.level     = row.exp_level;
                    typed_word.last_flag = 1'b1;
                    if (row.exp_status == ST_LOAD)
                        typed_word = '{row.idx, row.red, row.green, row.blue,
                                       row.exp_level, row.exp_status, 1'b1};
                    void'(pending_words.pop_back());
                    pending_words.push_back(typed_word);
                end
            end
        end
        directed = words_sent;

        random_words = 0;
        ph = 0;
        while (random_words < RAND_WORDS) begin
            drain_results();
            random_setting(ph);
            no_idle   = (ph % 4 == 3);
            phase_len = $urandom_range(18, 32);
            nw = 0;
            while (nw < phase_len) begin
                if ($urandom_range(0, 99) < 15) begin
                    send_random($urandom_range(0, 3));
                    nw++;
                end else begin
                    send_random(FUNC_RESTART);
                    nw++;
                    repeat ($urandom_range(0, 3)) begin
                        send_random(($urandom_range(0, 1) != 0) ? FUNC_BASE : FUNC_FRAME);
                        nw++;
                    end
                    repeat ($urandom_range(2, 8)) begin
                        send_random(FUNC_TICK);
                        nw++;
                    end
                end
            end
            random_words += nw;
            ph++;
        end
        phases = ph;
        no_idle = 1'b0;

        drain_results();
        repeat (SETTLE) @(posedge aclk);

        $display("Summary: %0d input words (%0d directed), %0d register writes, %0d random phases",
                 words_sent, directed, cfg_writes, phases);
        $display("Summary: %0d results: %0d frame pixels, %0d finished, %0d restart, %0d load",
                 words_checked, n_run, n_finish, n_restart, n_load);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d words still expected", mismatches,
                     pending_words.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
